/* sv/spt_pkg.sv */
// Shared constants and types for the stride prefetch table.
`default_nettype none
package spt_pkg;

   // Default table geometry.
   localparam int DEF_TABLE_ENTRIES = 512;
   localparam int DEF_ADDR_BITS = 32;

   // Width of the PC, access address, result and limit register.
   localparam int FIELD_W = 32;

   // Reset value of the maximum physical address register.
   localparam logic [FIELD_W-1:0] MAX_PHYS_RESET = '1;

   // Depth of the queue between the front and back parts.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QLVL_W = $clog2(QDEPTH + 1);

   // Queue status seen by the top level for flow control.
   typedef struct packed {
      logic              empty;
      logic [QLVL_W-1:0] level;
   } queue_status_type;

endpackage
`default_nettype wire

/* sv/spt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module spt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // The read returns the old contents when it meets a write to the same address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/spt_front.sv */
// Front part: accepts accesses and splits the PC into table slot and tag.
`default_nettype none
module spt_front #(
   parameter int TABLE_ENTRIES = spt_pkg::DEF_TABLE_ENTRIES,
   parameter int LAST_W = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 take,
   input  wire logic [spt_pkg::FIELD_W-1:0]          load_pc,
   input  wire logic [spt_pkg::FIELD_W-1:0]          access_addr,
   output logic      [1:0]                           inflight,
   output logic                                      push,
   output logic [(spt_pkg::FIELD_W - ($clog2(TABLE_ENTRIES + 1) - 1))
                 + $clog2(TABLE_ENTRIES) + LAST_W - 1:0] push_item
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int TAG_W = spt_pkg::FIELD_W - ($clog2(TABLE_ENTRIES + 1) - 1);
   localparam int SH = spt_pkg::FIELD_W + IDX_W;
   localparam int PROD_W = 2 * spt_pkg::FIELD_W + 1;
   // Rounded-up reciprocal: (pc * RECIP) >> SH equals pc / TABLE_ENTRIES for every 32-bit pc.
   localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(TABLE_ENTRIES) - 64'd1)
                                   / 64'(TABLE_ENTRIES);
   localparam logic [spt_pkg::FIELD_W-1:0] TE_W = spt_pkg::FIELD_W'(TABLE_ENTRIES);

   logic                          s1_vld_ff, s1_vld_in;
   logic [spt_pkg::FIELD_W-1:0]   s1_pc_ff;
   logic [LAST_W-1:0]             s1_addr_ff;
   logic [PROD_W-1:0]             s1_prod_ff, s1_prod_in;

   logic                          s2_vld_ff, s2_vld_in;
   logic [spt_pkg::FIELD_W-1:0]   s2_pc_ff;
   logic [LAST_W-1:0]             s2_addr_ff;
   logic [TAG_W-1:0]              s2_tag_ff, s2_tag_in;
   logic [spt_pkg::FIELD_W-1:0]   s2_qd_ff, s2_qd_in;
   logic [IDX_W-1:0]              slot;

   // Stage one multiplies the PC by the reciprocal of the table size.
   assign s1_vld_in = take;
   assign s1_prod_in = PROD_W'(load_pc) * PROD_W'(RECIP[spt_pkg::FIELD_W:0]);

   // Stage two takes the tag from the product and forms tag times table size.
   assign s2_vld_in = s1_vld_ff;
   assign s2_tag_in = TAG_W'(s1_prod_ff >> SH);
   assign s2_qd_in = spt_pkg::FIELD_W'(spt_pkg::FIELD_W'(s2_tag_in) * TE_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_pc_ff <= load_pc;
         s1_addr_ff <= access_addr[LAST_W-1:0];
         s1_prod_ff <= s1_prod_in;
      end
      if (s1_vld_ff) begin
         s2_pc_ff <= s1_pc_ff;
         s2_addr_ff <= s1_addr_ff;
         s2_tag_ff <= s2_tag_in;
         s2_qd_ff <= s2_qd_in;
      end
   end

   // The slot is the remainder left after removing tag times table size.
   assign slot = IDX_W'(s2_pc_ff - s2_qd_ff);

   assign push = s2_vld_ff;
   assign push_item = {s2_tag_ff, slot, s2_addr_ff};
   assign inflight = {1'b0, s1_vld_ff} + {1'b0, s2_vld_ff};

endmodule
`default_nettype wire

/* sv/spt_queue.sv */
// Short queue that decouples the front part from the back part.
`default_nettype none
module spt_queue #(
   parameter int ITEM_W = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [ITEM_W-1:0]          push_item,
   input  wire logic                       pop,
   output logic      [ITEM_W-1:0]          head_item,
   output spt_pkg::queue_status_type       status
);

   logic [ITEM_W-1:0]               slot_ff [spt_pkg::QDEPTH];
   logic [spt_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [spt_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [spt_pkg::QLVL_W-1:0]      count_ff, count_in;

   // Pointers wrap over the queue depth; the count tracks occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == spt_pkg::QPTR_W'(spt_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == spt_pkg::QPTR_W'(spt_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.level = count_ff;

endmodule
`default_nettype wire

/* sv/spt_back.sv */
// Back part: table lookup, stride check, table update and result strobe.
`default_nettype none
module spt_back #(
   parameter int TABLE_ENTRIES = spt_pkg::DEF_TABLE_ENTRIES,
   parameter int ADDR_BITS = spt_pkg::DEF_ADDR_BITS,
   parameter int LAST_W = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [spt_pkg::FIELD_W-1:0]          csr_wr_data,
   input  wire spt_pkg::queue_status_type            q_status,
   input  wire logic [(spt_pkg::FIELD_W - ($clog2(TABLE_ENTRIES + 1) - 1))
                      + $clog2(TABLE_ENTRIES) + LAST_W - 1:0] q_item,
   output logic                                      q_pop,
   output logic                                      clearing,
   output logic                                      rsp_valid,
   output logic      [spt_pkg::FIELD_W-1:0]          rsp_prefetch_addr
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int TAG_W = spt_pkg::FIELD_W - ($clog2(TABLE_ENTRIES + 1) - 1);
   localparam int WORD_W = 1 + TAG_W + LAST_W;
   localparam int CMP_W = (ADDR_BITS > spt_pkg::FIELD_W) ? ADDR_BITS : spt_pkg::FIELD_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   logic [spt_pkg::FIELD_W-1:0] max_phys_ff;

   logic                  clear_ff, clear_in;
   logic [IDX_W-1:0]      clr_idx_ff, clr_idx_in;

   logic [TAG_W-1:0]      q_tag;
   logic [IDX_W-1:0]      q_slot;
   logic [LAST_W-1:0]     q_addr;

   logic                  ex_vld_ff;
   logic [TAG_W-1:0]      ex_tag_ff;
   logic [IDX_W-1:0]      ex_slot_ff;
   logic [LAST_W-1:0]     ex_addr_ff;
   logic                  byp_ff, byp_in;
   logic [WORD_W-1:0]     byp_word_ff;

   logic [WORD_W-1:0]     rd_word;
   logic [WORD_W-1:0]     entry_word;
   logic [WORD_W-1:0]     ex_word;
   logic                  entry_valid;
   logic [TAG_W-1:0]      entry_tag;
   logic [LAST_W-1:0]     entry_last;
   logic                  hit;
   logic [ADDR_BITS-1:0]  stride;
   logic [ADDR_BITS-1:0]  cand;
   logic                  emit;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [WORD_W-1:0]     wr_data;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [spt_pkg::FIELD_W-1:0] rsp_addr_ff;

   // Maximum physical address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_phys_ff <= spt_pkg::MAX_PHYS_RESET;
      end else if (csr_wr_en) begin
         max_phys_ff <= csr_wr_data;
      end
   end

   // After reset, one sweep writes an empty word into every table entry.
   assign clear_in = clear_ff && (clr_idx_ff != LAST_IDX);
   assign clr_idx_in = clr_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else begin
         clear_ff <= clear_in;
         if (clear_ff) begin
            clr_idx_ff <= clr_idx_in;
         end
      end
   end

   assign clearing = clear_ff;

   // Read stage: pop one word and start the table read for its slot.
   assign {q_tag, q_slot, q_addr} = q_item;
   assign q_pop = !q_status.empty && !clear_ff;

   // The word being executed writes its slot this cycle; the read misses that write.
   assign byp_in = ex_vld_ff && (ex_slot_ff == q_slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff <= 1'b0;
      end else begin
         ex_vld_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ex_tag_ff <= q_tag;
         ex_slot_ff <= q_slot;
         ex_addr_ff <= q_addr;
         byp_ff <= byp_in;
         byp_word_ff <= ex_word;
      end
   end

   // Execute stage: compare the tag, form the stride and the candidate.
   assign entry_word = byp_ff ? byp_word_ff : rd_word;
   assign {entry_valid, entry_tag, entry_last} = entry_word;
   assign hit = entry_valid && (entry_tag == ex_tag_ff);
   assign stride = ADDR_BITS'(ex_addr_ff) - ADDR_BITS'(entry_last);
   assign cand = ADDR_BITS'(ex_addr_ff) + stride;
   assign emit = ex_vld_ff && hit && (CMP_W'(cand) <= CMP_W'(max_phys_ff));

   // A hit keeps the tag and a miss replaces it, so both write the same word.
   assign ex_word = {1'b1, ex_tag_ff, ex_addr_ff};

   assign wr_en = clear_ff || ex_vld_ff;
   assign wr_addr = clear_ff ? clr_idx_ff : ex_slot_ff;
   assign wr_data = clear_ff ? '0 : ex_word;

   spt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (q_pop),
      .rd_addr (q_slot),
      .rd_data (rd_word)
   );

   // Result register drives the one-cycle strobe.
   assign rsp_valid_in = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_addr_ff <= spt_pkg::FIELD_W'(cand);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_prefetch_addr = rsp_addr_ff;

endmodule
`default_nettype wire

/* sv/stride_prefetch_table.sv */
// Top level of the direct-mapped stride prefetcher.
//
//   Channel   Ports                                   Transfer
//   request   start, busy, req_load_pc,               word taken when start=1 and busy=0
//             req_access_addr
//   response  rsp_valid, rsp_prefetch_addr            one-cycle strobe, no back-pressure
//   csr       csr_wr_en, csr_wr_data                  max_phys_addr written when csr_wr_en=1
//
// One word is accepted per cycle while busy is low; a prefetch then passes the two
// multiply stages of the slot split, the queue, the table read and the result register.
// After reset a clearing pass sweeps the table, one entry per cycle, through all
// TABLE_ENTRIES entries; busy is high throughout and csr writes are still taken. After
// that the back part drains one word every cycle, so the queue guard never raises busy.
`default_nettype none
module stride_prefetch_table #(
   parameter int TABLE_ENTRIES = spt_pkg::DEF_TABLE_ENTRIES,
   parameter int ADDR_BITS = spt_pkg::DEF_ADDR_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [spt_pkg::FIELD_W-1:0]   req_load_pc,
   input  wire logic [spt_pkg::FIELD_W-1:0]   req_access_addr,
   output logic                               rsp_valid,
   output logic      [spt_pkg::FIELD_W-1:0]   rsp_prefetch_addr,
   input  wire logic                          csr_wr_en,
   input  wire logic [spt_pkg::FIELD_W-1:0]   csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int TAG_W = spt_pkg::FIELD_W - ($clog2(TABLE_ENTRIES + 1) - 1);
   localparam int LAST_W = (ADDR_BITS < spt_pkg::FIELD_W) ? ADDR_BITS : spt_pkg::FIELD_W;
   localparam int ITEM_W = TAG_W + IDX_W + LAST_W;
   localparam int SUM_W = spt_pkg::QLVL_W + 1;

   logic                          take;
   logic [1:0]                    inflight;
   logic                          push;
   logic [ITEM_W-1:0]             push_item;
   logic                          pop;
   logic [ITEM_W-1:0]             head_item;
   spt_pkg::queue_status_type     q_status;
   logic                          clearing;
   logic [SUM_W-1:0]              occupancy;

   // Hold off new words while clearing or when the queue could overflow.
   assign occupancy = SUM_W'(q_status.level) + SUM_W'(inflight);
   assign busy = clearing || (occupancy >= SUM_W'(spt_pkg::QDEPTH));
   assign take = start && !busy;

   spt_front #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .LAST_W        (LAST_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .load_pc     (req_load_pc),
      .access_addr (req_access_addr),
      .inflight    (inflight),
      .push        (push),
      .push_item   (push_item)
   );

   spt_queue #(
      .ITEM_W (ITEM_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   spt_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADDR_BITS     (ADDR_BITS),
      .LAST_W        (LAST_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .q_status          (q_status),
      .q_item            (head_item),
      .q_pop             (pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_prefetch_addr (rsp_prefetch_addr)
   );

endmodule
`default_nettype wire

/* tb/spt_checker.sv */
// Prediction and checking of prefetch words for the stride prefetch table.
`timescale 1ns / 1ps
module spt_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic [spt_pkg::FIELD_W-1:0]   req_load_pc,
   input  wire logic [spt_pkg::FIELD_W-1:0]   req_access_addr,
   input  wire logic                          rsp_valid,
   input  wire logic [spt_pkg::FIELD_W-1:0]   rsp_prefetch_addr,
   input  wire logic                          csr_wr_en,
   input  wire logic [spt_pkg::FIELD_W-1:0]   csr_wr_data,
   output int                                 error_count,
   output int                                 pending_count,
   output int                                 words_taken,
   output int                                 prefetch_count
);

   localparam int FIELD_W = spt_pkg::FIELD_W;
   localparam int ENTRIES = spt_pkg::DEF_TABLE_ENTRIES;
   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int TAG_W = FIELD_W - SLOT_W;
   localparam int REPORT_LIMIT = 10;

   // Shadow copy of the reference table and the address limit.
   logic               shadow_valid [ENTRIES];
   logic [TAG_W-1:0]   shadow_tag [ENTRIES];
   logic [FIELD_W-1:0] shadow_last [ENTRIES];
   logic [FIELD_W-1:0] addr_limit;

   // Prefetch words still owed by the block, oldest first.
   logic [FIELD_W-1:0] owed_prefetch [$];

   int errors = 0;
   int taken = 0;
   int seen = 0;

   // Looks up the table for one access and queues the prefetch it should raise.
   task automatic predict_prefetch(input logic [FIELD_W-1:0] pc, input logic [FIELD_W-1:0] addr);
      logic [SLOT_W-1:0]  slot;
      logic [TAG_W-1:0]   tag;
      logic [FIELD_W-1:0] stride;
      logic [FIELD_W-1:0] target;
      slot = pc[SLOT_W-1:0];
      tag = pc[FIELD_W-1:SLOT_W];
      if (shadow_valid[slot] && shadow_tag[slot] == tag) begin
         // Stride and target wrap at the full address width.
         stride = addr - shadow_last[slot];
         target = addr + stride;
         shadow_last[slot] = addr;
         if (target <= addr_limit) begin
            owed_prefetch.push_back(target);
         end
      end else begin
         shadow_valid[slot] = 1'b1;
         shadow_tag[slot] = tag;
         shadow_last[slot] = addr;
      end
   endtask

   // Counts a failure and prints the first few of them.
   task automatic flag_error(input string what, input logic [FIELD_W-1:0] want,
                             input logic [FIELD_W-1:0] got);
      if (errors < REPORT_LIMIT) begin
         $display("[%0t] %s: expected prefetch 0x%08h, got 0x%08h", $realtime, what, want, got);
      end
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
         end
         addr_limit = spt_pkg::MAX_PHYS_RESET;
         owed_prefetch.delete();
      end else begin
         if (csr_wr_en) begin
            addr_limit = csr_wr_data;
         end
         // Compare each returned word against the oldest one owed.
         if (rsp_valid) begin
            seen++;
            if (owed_prefetch.size() == 0) begin
               flag_error("Unexpected prefetch word", '0, rsp_prefetch_addr);
            end else if (owed_prefetch[0] !== rsp_prefetch_addr) begin
               flag_error("Prefetch address mismatch", owed_prefetch[0], rsp_prefetch_addr);
               void'(owed_prefetch.pop_front());
            end else begin
               void'(owed_prefetch.pop_front());
            end
         end
         if (start && !busy) begin
            taken++;
            predict_prefetch(req_load_pc, req_access_addr);
         end
      end
      error_count <= errors;
      pending_count <= owed_prefetch.size();
      words_taken <= taken;
      prefetch_count <= seen;
   end

endmodule

/* tb/tb_top.sv */
// Stimulus and verdict for the stride prefetch table testbench.
`timescale 1ns / 1ps
module tb_top;

   localparam int FIELD_W = spt_pkg::FIELD_W;
   localparam int STREAMS = 16;
   localparam int PHASE_WORDS = 255;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_BOUND = 400;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [FIELD_W-1:0] req_load_pc = '0;
   logic [FIELD_W-1:0] req_access_addr = '0;
   logic               rsp_valid;
   logic [FIELD_W-1:0] rsp_prefetch_addr;
   logic               csr_wr_en = 1'b0;
   logic [FIELD_W-1:0] csr_wr_data = '0;

   int error_count;
   int pending_count;
   int words_taken;
   int prefetch_count;

   // Access streams: each is one load walking memory with its own stride.
   logic [FIELD_W-1:0] stream_pc [STREAMS];
   logic [FIELD_W-1:0] stream_addr [STREAMS];
   logic [FIELD_W-1:0] stream_stride [STREAMS];
   int current_stream = 0;
   int burst_left = 0;
   int limit_writes = 0;

   always #4 clock = ~clock;

   stride_prefetch_table i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_load_pc       (req_load_pc),
      .req_access_addr   (req_access_addr),
      .rsp_valid         (rsp_valid),
      .rsp_prefetch_addr (rsp_prefetch_addr),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   spt_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_load_pc       (req_load_pc),
      .req_access_addr   (req_access_addr),
      .rsp_valid         (rsp_valid),
      .rsp_prefetch_addr (rsp_prefetch_addr),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .error_count       (error_count),
      .pending_count     (pending_count),
      .words_taken       (words_taken),
      .prefetch_count    (prefetch_count)
   );

   // Idle gap before the next word: mostly none or short, now and then long,
   // with occasional bursts that have no gaps at all.
   function automatic int next_gap();
      int pick;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         burst_left = $urandom_range(20, 60);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [FIELD_W-1:0] pick_stride();
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2, 3, 4: return FIELD_W'($urandom_range(1, 64) * 4);
         5, 6: return -FIELD_W'($urandom_range(1, 64) * 8);
         7: return FIELD_W'(1);
         default: return $urandom();
      endcase
   endfunction

   // Odd streams in the upper half share a table slot with their neighbor.
   task automatic reseed_stream(input int k);
      stream_pc[k] = $urandom();
      if (k >= STREAMS / 2 && k % 2 == 1) begin
         stream_pc[k][8:0] = stream_pc[k-1][8:0];
      end
      stream_addr[k] = $urandom();
      stream_stride[k] = pick_stride();
   endtask

   // Presents one word, holds it until the block takes it, then idles for a random gap.
   task automatic send_word(input logic [FIELD_W-1:0] pc, input logic [FIELD_W-1:0] addr);
      int gap;
      start <= 1'b1;
      req_load_pc <= pc;
      req_access_addr <= addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits, within a bound, for every owed prefetch word, then lets the pipe empty.
   task automatic settle_idle();
      int waited;
      waited = 0;
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 && waited < DRAIN_BOUND) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [FIELD_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_writes++;
   endtask

   // Mostly stride streams with random content, some noise and broken strides.
   task automatic run_streams(input int count);
      int k;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_word($urandom(), $urandom());
         end else begin
            k = (pick < 55) ? current_stream : $urandom_range(0, STREAMS - 1);
            current_stream = k;
            if (pick < 18) begin
               send_word(stream_pc[k], $urandom());
            end else begin
               if ($urandom_range(0, 19) == 0) stream_stride[k] = pick_stride();
               if ($urandom_range(0, 49) == 0) reseed_stream(k);
               stream_addr[k] = stream_addr[k] + stream_stride[k];
               send_word(stream_pc[k], stream_addr[k]);
            end
         end
      end
   endtask

   initial begin
      logic [FIELD_W-1:0] phase_limit [6];
      int fails;
      for (int k = 0; k < STREAMS; k++) begin
         reseed_stream(k);
      end
      phase_limit = '{spt_pkg::MAX_PHYS_RESET, $urandom(), 32'h7FFF_FFFF, '0, $urandom(),
                      32'hFFFF_FFFE};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty entry with a matching tag, then stride, zero and negative strides.
      send_word(32'h0000_0000, 32'h0000_1000);
      send_word(32'h0000_0000, 32'h0000_1040);
      send_word(32'h0000_0000, 32'h0000_1040);
      send_word(32'h0000_0000, 32'h0000_1000);
      // An alias in the same slot evicts the entry.
      send_word(32'h0000_0200, 32'h0000_0000);
      send_word(32'h0000_0000, 32'h0000_1000);
      // Extreme PC and address values, with wrap of stride and target.
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFF, 32'h0000_0000);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFF0);
      send_word(32'h1234_5678, 32'hF000_0000);
      send_word(32'h1234_5678, 32'hF800_0000);
      send_word(32'h0000_01FF, 32'h7FFF_FFFF);
      send_word(32'h0000_01FF, 32'h8000_0000);
      settle_idle();

      // Targets above the limit are dropped but still move the last address.
      write_limit(32'h8000_0000);
      send_word(32'h0000_01FF, 32'h8000_0001);
      send_word(32'h0000_01FF, 32'h7FFF_FFFF);
      send_word(32'h0000_01FF, 32'h8000_0000);
      send_word(32'h0000_01FF, 32'h4000_0000);
      settle_idle();

      // With a zero limit only a target of zero gets through.
      write_limit('0);
      send_word(32'h0000_0005, 32'h0000_0010);
      send_word(32'h0000_0005, 32'h0000_0008);
      send_word(32'h0000_0005, 32'h0000_0008);
      settle_idle();

      // Random phases, one limit setting each.
      foreach (phase_limit[p]) begin
         write_limit(phase_limit[p]);
         run_streams(PHASE_WORDS);
         settle_idle();
      end

      fails = error_count + pending_count;
      if (pending_count != 0) begin
         $display("%0d expected prefetch words never arrived", pending_count);
      end
      $display("Sent %0d access words and checked %0d prefetch words under %0d limit settings.",
               words_taken, prefetch_count, limit_writes);
      $display("Mismatches: %0d", error_count);
      if (fails == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5_000_000;
      $display("Timeout: the run did not finish in time");
      $display("Test completed with failures");
      $finish;
   end

endmodule
